// File: src/ihsp_pkg.sv
package ihsp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 5;
  localparam int unsigned DimW  = 32;
  localparam int unsigned JDimW = 16;
  localparam int unsigned OutW  = 72;

  // detected format
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_GIF  = 3'd1;
  localparam logic [2:0] FMT_BMP  = 3'd2;
  localparam logic [2:0] FMT_PNG  = 3'd3;
  localparam logic [2:0] FMT_JPEG = 3'd4;

  // marker walk phase
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_SOF    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  // marker walk outcome
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_SIZE = 2'd1;
  localparam logic [1:0] WR_END  = 2'd2;
  localparam logic [1:0] WR_ERR  = 2'd3;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SIZE   = 2'd1;
  localparam logic [1:0] ST_MARK_ERR  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  // JPEG marker bytes
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_STUFF  = 8'h00;

  localparam logic [7:0] PNG_MAGIC = 8'd137;

  typedef struct packed {
    logic [2:0]       phase;
    logic [1:0]       result;
    logic [JDimW-1:0] width;
    logic [JDimW-1:0] height;
  } walk_t;

endpackage

// File: src/image_header_size_parser.sv
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready   tdata[7:0] data_byte, tlast final_byte
// out_      out  out_tvalid/out_tready tdata[1:0] status, [33:2] image_width,
//                                      [65:34] image_height, [71:66] zero
// One byte is taken per cycle while in_tready is high; all per-byte state
// updates in the same cycle. The word with tlast set loads the result register,
// which shows it on the next cycle. in_tready is low only while a result waits
// and out_tready is low. Reset (rst_n low, synchronous) clears all parse state
// and the valid flag, not the result data; after each result parse state resets too.
module image_header_size_parser
  import ihsp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] data_byte
  input  logic            in_tlast,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata   // [1:0] status, [33:2] image_width,
                                      // [65:34] image_height
);

  logic [PosW-1:0]  pos_r;
  logic [2:0]       fmt_r;
  logic             sig_r;
  logic [DimW-1:0]  wacc_r;
  logic [DimW-1:0]  hacc_r;
  logic [15:0]      trail_r;
  logic             out_valid_r;
  logic [OutW-1:0]  out_data_r;

  logic [2:0]       fmt_nxt;
  logic             sig_nxt;
  logic             sig_ok;
  logic [DimW-1:0]  wacc_nxt;
  logic [DimW-1:0]  hacc_nxt;
  logic [15:0]      trail_nxt;
  logic [1:0]       status;
  logic [DimW-1:0]  width_sel;
  logic [DimW-1:0]  height_sel;
  logic             accept;
  logic             last_acc;
  logic [ByteW-1:0] b;
  walk_t            walk_nxt;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign last_acc  = accept && in_tlast;

  always_comb begin
    if (pos_r == '0) begin
      if (b == "G") begin
        fmt_nxt = FMT_GIF;
      end else if (b == "B") begin
        fmt_nxt = FMT_BMP;
      end else if (b == PNG_MAGIC) begin
        fmt_nxt = FMT_PNG;
      end else if (b == MK_PREFIX) begin
        fmt_nxt = FMT_JPEG;
      end else begin
        fmt_nxt = FMT_NONE;
      end
    end else begin
      fmt_nxt = fmt_r;
    end
  end

  // signature bytes after the first
  always_comb begin
    sig_ok = 1'b1;
    if (pos_r != '0) begin
      unique case (fmt_r)
        FMT_GIF: begin
          case (pos_r)
            5'd1:    sig_ok = (b == "I");
            5'd2:    sig_ok = (b == "F");
            5'd3:    sig_ok = (b == "8");
            5'd4:    sig_ok = (b == "7") || (b == "9");
            5'd5:    sig_ok = (b == "a");
            default: sig_ok = 1'b1;
          endcase
        end
        FMT_BMP:  sig_ok = (pos_r != 5'd1) || (b == "M");
        FMT_PNG: begin
          case (pos_r)
            5'd1:    sig_ok = (b == "P");
            5'd2:    sig_ok = (b == "N");
            5'd3:    sig_ok = (b == "G");
            default: sig_ok = 1'b1;
          endcase
        end
        FMT_JPEG: sig_ok = (pos_r != 5'd1) || (b == MK_SOI);
        default:  sig_ok = 1'b1;
      endcase
    end
  end

  assign sig_nxt   = sig_r && sig_ok;
  assign trail_nxt = {trail_r[7:0], b};

  // fixed-offset size capture
  always_comb begin
    wacc_nxt = wacc_r;
    hacc_nxt = hacc_r;
    unique case (fmt_nxt)
      FMT_GIF: begin
        case (pos_r)
          5'd6:    wacc_nxt[7:0]  = b;
          5'd7:    wacc_nxt[15:8] = b;
          5'd8:    hacc_nxt[7:0]  = b;
          5'd9:    hacc_nxt[15:8] = b;
          default: ;
        endcase
      end
      FMT_BMP: begin
        case (pos_r)
          5'd18:   wacc_nxt[7:0]   = b;
          5'd19:   wacc_nxt[15:8]  = b;
          5'd20:   wacc_nxt[23:16] = b;
          5'd21:   wacc_nxt[31:24] = b;
          5'd22:   hacc_nxt[7:0]   = b;
          5'd23:   hacc_nxt[15:8]  = b;
          default: ;
        endcase
      end
      FMT_PNG: begin
        if (pos_r >= 5'd16 && pos_r <= 5'd19) begin
          wacc_nxt = {wacc_r[23:0], b};
        end else if (pos_r >= 5'd20 && pos_r <= 5'd23) begin
          hacc_nxt = {hacc_r[23:0], b};
        end
      end
      default: ;
    endcase
  end

  ihsp_jpeg_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept && (fmt_nxt == FMT_JPEG)),
    .clear     (last_acc),
    .data_byte (b),
    .walk_nxt  (walk_nxt)
  );

  always_comb begin
    if (fmt_nxt == FMT_NONE || !sig_nxt) begin
      status = ST_NO_SIZE;
    end else if (fmt_nxt == FMT_GIF) begin
      status = (pos_r < 5'd9) ? ST_TRUNCATED : ST_OK;
    end else if (fmt_nxt == FMT_BMP || fmt_nxt == FMT_PNG) begin
      status = (pos_r < 5'd23) ? ST_TRUNCATED : ST_OK;
    end else if (trail_nxt != {MK_PREFIX, MK_EOI}) begin
      status = ST_NO_SIZE;
    end else begin
      unique case (walk_nxt.result)
        WR_SIZE: status = ST_OK;
        WR_END:  status = ST_NO_SIZE;
        WR_ERR:  status = ST_MARK_ERR;
        default: begin
          if (walk_nxt.phase == PH_ID) begin
            status = ST_MARK_ERR;
          end else if (walk_nxt.phase == PH_LEN_HI || walk_nxt.phase == PH_LEN_LO ||
                       walk_nxt.phase == PH_SOF) begin
            status = ST_TRUNCATED;
          end else begin
            status = ST_NO_SIZE;
          end
        end
      endcase
    end
  end

  always_comb begin
    width_sel  = '0;
    height_sel = '0;
    if (status == ST_OK) begin
      if (fmt_nxt == FMT_JPEG) begin
        width_sel  = {16'd0, walk_nxt.width};
        height_sel = {16'd0, walk_nxt.height};
      end else begin
        width_sel  = wacc_nxt;
        height_sel = hacc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last_acc) begin
      pos_r   <= '0;
      fmt_r   <= FMT_NONE;
      sig_r   <= 1'b1;
      wacc_r  <= '0;
      hacc_r  <= '0;
      trail_r <= 16'd0;
    end else if (accept) begin
      // hold at the top so offsets beyond the headers stay out of range
      if (pos_r != '1) begin
        pos_r <= pos_r + 5'd1;
      end
      fmt_r   <= fmt_nxt;
      sig_r   <= sig_nxt;
      wacc_r  <= wacc_nxt;
      hacc_r  <= hacc_nxt;
      trail_r <= trail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_acc) begin
      out_data_r <= {6'd0, height_sel, width_sel, status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/ihsp_jpeg_walk.sv
module ihsp_jpeg_walk
  import ihsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             clear,
  input  logic [ByteW-1:0] data_byte,
  output walk_t            walk_nxt
);

  logic [2:0]       phase_r;
  logic [1:0]       result_r;
  logic [15:0]      seg_r;
  logic [JDimW-1:0] width_r;
  logic [JDimW-1:0] height_r;

  logic [15:0] seg_nxt;
  logic [15:0] len;
  logic [15:0] seg_dec;

  always_comb begin
    walk_nxt.phase  = phase_r;
    walk_nxt.result = result_r;
    walk_nxt.width  = width_r;
    walk_nxt.height = height_r;
    seg_nxt         = seg_r;
    len             = seg_r | {8'd0, data_byte};
    seg_dec         = seg_r - 16'd1;
    if (step_en && (result_r == WR_NONE)) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (data_byte != MK_PREFIX) begin
            walk_nxt.result = WR_ERR;
            walk_nxt.phase  = PH_DONE;
          end else begin
            walk_nxt.phase = PH_ID;
          end
        end
        PH_ID: begin
          if (data_byte == MK_SOI) begin
            walk_nxt.phase = PH_PREFIX;
          end else if (data_byte == MK_SOF0) begin
            seg_nxt        = 16'd0;
            walk_nxt.phase = PH_SOF;
          end else if (data_byte == MK_SOS || data_byte == MK_EOI ||
                       data_byte == MK_STUFF) begin
            walk_nxt.result = WR_END;
            walk_nxt.phase  = PH_DONE;
          end else begin
            walk_nxt.phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          seg_nxt        = {data_byte, 8'd0};
          walk_nxt.phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len < 16'd2) begin
            walk_nxt.result = WR_ERR;
            walk_nxt.phase  = PH_DONE;
          end else begin
            seg_nxt        = len - 16'd2;
            walk_nxt.phase = (len == 16'd2) ? PH_PREFIX : PH_SKIP;
          end
        end
        PH_SKIP: begin
          seg_nxt = seg_dec;
          if (seg_dec == 16'd0) begin
            walk_nxt.phase = PH_PREFIX;
          end
        end
        PH_SOF: begin
          // bytes 3..4 after the marker are height, 5..6 width
          if (seg_r == 16'd3 || seg_r == 16'd4) begin
            walk_nxt.height = {height_r[7:0], data_byte};
          end else if (seg_r == 16'd5 || seg_r == 16'd6) begin
            walk_nxt.width = {width_r[7:0], data_byte};
          end
          if (seg_r == 16'd6) begin
            walk_nxt.result = WR_SIZE;
            walk_nxt.phase  = PH_DONE;
          end else begin
            seg_nxt = seg_r + 16'd1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r  <= PH_PREFIX;
      result_r <= WR_NONE;
      seg_r    <= 16'd0;
      width_r  <= '0;
      height_r <= '0;
    end else begin
      phase_r  <= walk_nxt.phase;
      result_r <= walk_nxt.result;
      seg_r    <= seg_nxt;
      width_r  <= walk_nxt.width;
      height_r <= walk_nxt.height;
    end
  end

endmodule

// File: tb/header_dim_checker.sv
module header_dim_checker
  import ihsp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] data_byte
  input  logic            in_tlast,
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [OutW-1:0] out_tdata,  // [1:0] status, [33:2] image_width,
                                      // [65:34] image_height
  output int unsigned     n_due,
  output int unsigned     n_fail
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] GIF_SIG  = "GIF87a";
  localparam logic [15:0] BMP_SIG  = "BM";
  localparam logic [31:0] PNG_SIG  = {PNG_MAGIC, "PNG"};
  localparam logic [15:0] JPEG_SIG = {MK_PREFIX, MK_SOI};
  localparam logic [15:0] JPEG_END = {MK_PREFIX, MK_EOI};

  typedef struct packed {
    logic [1:0]      status;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } dims_t;

  dims_t dims_due[$];
  dims_t want;
  int unsigned fails = 0;

  logic [PosW-1:0] pos;
  logic [2:0]      fmt;
  logic            sig_ok;
  logic [2:0]      phase;
  logic [15:0]     seg_left;
  logic [DimW-1:0] w_acc;
  logic [DimW-1:0] h_acc;
  logic [1:0]      walk_res;
  logic [15:0]     tail;

  task automatic clear_parse();
    pos      = '0;
    fmt      = FMT_NONE;
    sig_ok   = 1'b1;
    phase    = PH_PREFIX;
    seg_left = '0;
    w_acc    = '0;
    h_acc    = '0;
    walk_res = WR_NONE;
    tail     = '0;
  endtask

  task automatic track_header_byte(input logic [7:0] b, input logic last);
    logic [PosW-1:0] p;
    logic            ok;
    logic [15:0]     len;
    logic [1:0]      st;
    dims_t           d;
    p = pos;
    if (p == 0) begin
      case (b)
        "G":       fmt = FMT_GIF;
        "B":       fmt = FMT_BMP;
        PNG_MAGIC: fmt = FMT_PNG;
        MK_PREFIX: fmt = FMT_JPEG;
        default:   fmt = FMT_NONE;
      endcase
    end else begin
      ok = 1'b1;
      case (fmt)
        FMT_GIF:  if (p < 6) ok = (b == GIF_SIG[8*(5-p) +: 8]) || (p == 4 && b == "9");
        FMT_BMP:  if (p < 2) ok = (b == BMP_SIG[8*(1-p) +: 8]);
        FMT_PNG:  if (p < 4) ok = (b == PNG_SIG[8*(3-p) +: 8]);
        FMT_JPEG: if (p < 2) ok = (b == JPEG_SIG[8*(1-p) +: 8]);
        default: ;
      endcase
      if (!ok) sig_ok = 1'b0;
    end

    // fixed-offset size fields
    case (fmt)
      FMT_GIF: begin
        if (p == 6 || p == 7) w_acc |= DimW'(b) << (8*(p-6));
        else if (p == 8 || p == 9) h_acc |= DimW'(b) << (8*(p-8));
      end
      FMT_BMP: begin
        if (p >= 18 && p <= 21) w_acc |= DimW'(b) << (8*(p-18));
        else if (p == 22 || p == 23) h_acc |= DimW'(b) << (8*(p-22));
      end
      FMT_PNG: begin
        if (p >= 16 && p <= 19) w_acc = {w_acc[23:0], b};
        else if (p >= 20 && p <= 23) h_acc = {h_acc[23:0], b};
      end
      default: ;
    endcase

    // marker walk, frozen once it has an outcome
    if (fmt == FMT_JPEG && walk_res == WR_NONE) begin
      case (phase)
        PH_PREFIX: begin
          if (b != MK_PREFIX) begin
            walk_res = WR_ERR;
            phase    = PH_DONE;
          end else begin
            phase = PH_ID;
          end
        end
        PH_ID: begin
          if (b == MK_SOI) begin
            phase = PH_PREFIX;
          end else if (b == MK_SOF0) begin
            seg_left = '0;
            phase    = PH_SOF;
          end else if (b == MK_SOS || b == MK_EOI || b == MK_STUFF) begin
            walk_res = WR_END;
            phase    = PH_DONE;
          end else begin
            phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          seg_left = {b, 8'h00};
          phase    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len = seg_left | {8'h00, b};
          if (len < 2) begin
            walk_res = WR_ERR;
            phase    = PH_DONE;
          end else begin
            seg_left = len - 16'd2;
            phase    = (seg_left == 0) ? PH_PREFIX : PH_SKIP;
          end
        end
        PH_SKIP: begin
          seg_left = seg_left - 16'd1;
          if (seg_left == 0) phase = PH_PREFIX;
        end
        PH_SOF: begin
          // skip length and precision, then height and width big-endian
          if (seg_left == 3 || seg_left == 4) h_acc = {16'h0000, h_acc[7:0], b};
          else if (seg_left == 5 || seg_left == 6) w_acc = {16'h0000, w_acc[7:0], b};
          if (seg_left == 6) begin
            walk_res = WR_SIZE;
            phase    = PH_DONE;
          end else begin
            seg_left = seg_left + 16'd1;
          end
        end
        default: ;
      endcase
    end
    tail = {tail[7:0], b};

    if (!last) begin
      if (pos != '1) pos = pos + 1'b1;
    end else begin
      if (fmt == FMT_NONE || !sig_ok) begin
        st = ST_NO_SIZE;
      end else if (fmt == FMT_GIF) begin
        st = (p < 9) ? ST_TRUNCATED : ST_OK;
      end else if (fmt == FMT_BMP || fmt == FMT_PNG) begin
        st = (p < 23) ? ST_TRUNCATED : ST_OK;
      end else if (tail != JPEG_END) begin
        st = ST_NO_SIZE;
      end else begin
        case (walk_res)
          WR_SIZE: st = ST_OK;
          WR_END:  st = ST_NO_SIZE;
          WR_ERR:  st = ST_MARK_ERR;
          default: begin
            case (phase)
              PH_ID:                      st = ST_MARK_ERR;
              PH_LEN_HI, PH_LEN_LO, PH_SOF: st = ST_TRUNCATED;
              default:                    st = ST_NO_SIZE;
            endcase
          end
        endcase
      end
      d.status = st;
      d.width  = (st == ST_OK) ? w_acc : '0;
      d.height = (st == ST_OK) ? h_acc : '0;
      dims_due.push_back(d);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      dims_due.delete();
    end else begin
      // retire the result first: a new last word may land on the same edge
      if (out_tvalid && out_tready) begin
        if (dims_due.size() == 0) begin
          $error("result word with no pending expectation: status %0d", out_tdata[1:0]);
          fails++;
        end else begin
          want = dims_due.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
            fails++;
          end
          if (out_tdata[2 +: DimW] !== want.width) begin
            $error("image_width: expected %0d, got %0d", want.width, out_tdata[2 +: DimW]);
            fails++;
          end
          if (out_tdata[2+DimW +: DimW] !== want.height) begin
            $error("image_height: expected %0d, got %0d", want.height,
                   out_tdata[2+DimW +: DimW]);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) track_header_byte(in_tdata, in_tlast);
    end
    n_due  <= dims_due.size();
    n_fail <= fails;
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ihsp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [7:0]      in_tdata;   // [7:0] data_byte
  logic            in_tlast;
  logic            out_tvalid;
  logic            out_tready;
  logic [OutW-1:0] out_tdata;  // [1:0] status, [33:2] image_width, [65:34] image_height
  int unsigned     n_due;
  int unsigned     n_fail;

  logic            idle_on = 1'b1;
  bit              stall_req = 1'b0;
  int unsigned     cycles = 0;
  logic [7:0]      img[$];
  int unsigned     rand_bytes = 0;
  int unsigned     nfiles = 0;
  int unsigned     kind;
  int unsigned     k;

  image_header_size_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  header_dim_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .n_due      (n_due),
    .n_fail     (n_fail)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold = 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 19);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap = 0;
    if (idle_on) while ($urandom_range(99) < 19) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_img();
    for (int i = 0; i < img.size(); i++) send_word(img[i], i == img.size() - 1);
  endtask

  // hold the input until every predicted result has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_due != 0) @(posedge clk);
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endtask

  task automatic push_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) img.push_back(v[8*i +: 8]);
  endtask

  task automatic push_rand(input int n);
    repeat (n) img.push_back(8'($urandom_range(255)));
  endtask

  function automatic logic [31:0] pick_dim(input int unsigned bits);
    logic [31:0] mask;
    mask = (bits == 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic build_jpeg();
    int unsigned len;
    logic [7:0]  id;
    push_be(32'({MK_PREFIX, MK_SOI}), 2);
    repeat ($urandom_range(3)) begin
      if ($urandom_range(9) == 0) push_be(32'({MK_PREFIX, MK_SOI}), 2);
      case ($urandom_range(6))
        0:       id = 8'hDB;
        1:       id = 8'hC4;
        2:       id = 8'hDC;
        3:       id = 8'hDD;
        4:       id = 8'hEF;
        default: id = 8'($urandom_range(8'hE0, 8'hEF));
      endcase
      len = ($urandom_range(19) == 0) ? 256 + $urandom_range(4) : $urandom_range(2, 8);
      push_be(32'({MK_PREFIX, id}), 2);
      push_be(len, 2);
      push_rand(len - 2);
    end
    case ($urandom_range(3))
      0, 1: begin
        push_be(32'({MK_PREFIX, MK_SOF0}), 2);
        push_rand(3);
        push_be(pick_dim(16), 2);
        push_be(pick_dim(16), 2);
        push_rand($urandom_range(6));
      end
      2: begin
        push_be(32'({MK_PREFIX, MK_SOS}), 2);
        push_rand($urandom_range(6));
      end
      default: ;
    endcase
    push_be(32'({MK_PREFIX, MK_EOI}), 2);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // GIF extremes, both versions, then BMP and PNG extremes
    img.delete(); push_be("GIF8", 4); push_be(32'("7a"), 2); push_le(0, 2);
    push_le(32'h0000_FFFF, 2);
    send_img();
    img.delete(); push_be("GIF8", 4); push_be(32'("9a"), 2); push_le(32'h0000_FFFF, 2);
    push_le(0, 2);
    push_rand(1);
    send_img();
    img.delete(); push_be(32'("BM"), 2); push_rand(16); push_le(32'hFFFF_FFFF, 4);
    push_le(0, 2);
    send_img();
    img.delete(); push_be({PNG_MAGIC, "PNG"}, 4); push_rand(12); push_be(0, 4);
    push_be(32'hFFFF_FFFF, 4);
    send_img();
    // JPEG with a SOF0 size
    img.delete(); push_be(32'hFFD8_FFC0, 4); push_be(32'h0000_1108, 3);
    push_be(32'h1234_ABCD, 4);
    push_be(32'({MK_PREFIX, MK_EOI}), 2);
    send_img();
    // empty APP0 segment, then scan start
    img.delete(); push_be(32'hFFD8_FFE0, 4); push_be(32'h0002_FFDA, 4);
    push_be(32'h0055_FFD9, 3);
    send_img();
    // DQT, DHT, DNL, DRI and APP15 segments, walk ended by a stuffed zero
    img.delete(); push_be(32'hFFD8_FFDB, 4); push_be(32'h0000_03AA, 3);
    push_be(32'hFFC4_0002, 4);
    push_be(32'hFFDC_0002, 4); push_be(32'hFFDD_0002, 4); push_be(32'hFFEF_0002, 4);
    push_be(32'hFF00_FFD9, 4);
    send_img();
    // unknown first byte
    img.delete(); push_be(0, 1);
    send_img();
    img.delete(); push_be(32'("AB"), 2);
    send_img();
    // signature mismatch
    img.delete(); push_be("GIF8", 4); push_be(32'("8a"), 2); push_rand(4);
    send_img();
    // truncated fixed formats
    img.delete(); push_be("GIF8", 4);
    send_img();
    img.delete(); push_be(32'("BM"), 2);
    send_img();
    img.delete(); push_be({PNG_MAGIC, "PNG"}, 4); push_rand(16);
    send_img();
    // JPEG that does not end in EOI
    img.delete(); push_be(32'hFFD8_FFC0, 4); push_be(32'h0000_1108, 3);
    push_be(32'h1234_ABCD, 4);
    push_be(0, 1);
    send_img();
    // bad marker prefix
    img.delete(); push_be(32'hFFD8_12FF, 4); push_be(32'h0000_00D9, 1);
    send_img();
    // segment length below two
    img.delete(); push_be(32'hFFD8_FFE0, 4); push_be(32'h0001_FFD9, 4);
    send_img();
    // end inside a skipped segment
    img.delete(); push_be(32'hFFD8_FFE0, 4); push_be(32'h0006_FFD9, 4);
    send_img();
    // end right after a prefix byte
    img.delete(); push_be(32'h00FF_D8FF, 3);
    send_img();
    // end inside a segment length, then inside the SOF0 segment length
    img.delete(); push_be(32'hFFD8_FFFF, 4); push_be(32'h0000_00D9, 1);
    send_img();
    img.delete(); push_be(32'hFFD8_FFC0, 4); push_be(32'h0000_FFD9, 2);
    send_img();

    while (rand_bytes < 300 || nfiles < 12) begin
      if (nfiles == 2) stall_req = 1'b1;
      if (nfiles == 4) wait_drained();
      idle_on = !(nfiles >= 6 && nfiles < 11);
      img.delete();
      kind = $urandom_range(99);
      if (kind < 18) begin
        push_be("GIF8", 4);
        push_be($urandom_range(1) ? 32'("9a") : 32'("7a"), 2);
        push_le(pick_dim(16), 2);
        push_le(pick_dim(16), 2);
        push_rand($urandom_range(6));
      end else if (kind < 33) begin
        push_be(32'("BM"), 2);
        push_rand(16);
        push_le(pick_dim(32), 4);
        push_le(pick_dim(16), 2);
        push_rand($urandom_range(6));
      end else if (kind < 48) begin
        push_be({PNG_MAGIC, "PNG"}, 4);
        push_rand(12);
        push_be(pick_dim(32), 4);
        push_be(pick_dim(32), 4);
        push_rand($urandom_range(6));
      end else if (kind < 82) begin
        build_jpeg();
      end else begin
        push_rand($urandom_range(1, 16));
      end
      // corrupt or cut some of the files
      if ($urandom_range(4) == 0) begin
        k = $urandom_range(img.size() - 1);
        if ($urandom_range(1)) img[k] = 8'($urandom_range(255));
        else while (img.size() > k + 1) void'(img.pop_back());
      end
      rand_bytes += img.size();
      nfiles++;
      send_img();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
